@@ src/bm_pkg.sv @@
// ----------------------------------------------------------------------------
// bm_pkg
// Shared types and constants for the buffer median block: word structs,
// shared unit opcodes and result struct.
// ----------------------------------------------------------------------------
package bm_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int MAX_SAMPLES_DEF = 64;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_of_set;
    } bm_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] median;
        logic                       overflowed;
    } bm_out_t;

    typedef enum logic {
        OP_CMP,
        OP_ADD
    } bm_op_t;

    typedef struct packed {
        logic                gt;
        logic [SAMPLE_W:0]   sum;
    } bm_unit_res_t;

endpackage

@@ src/bm_ram.sv @@
// ----------------------------------------------------------------------------
// bm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/bm_unit.sv @@
// ----------------------------------------------------------------------------
// bm_unit
// Shared 33-bit adder: signed greater-than compare for the insertion walk,
// sum of the two middle entries for the median.
// ----------------------------------------------------------------------------
module bm_unit
    import bm_pkg::*;
(
    input  bm_op_t              op,
    input  logic [SAMPLE_W-1:0] a,
    input  logic [SAMPLE_W-1:0] b,
    output bm_unit_res_t        res
);

    logic [SAMPLE_W:0] a_ext;
    logic [SAMPLE_W:0] b_ext;
    logic [SAMPLE_W:0] b_op;
    logic              cin;
    logic [SAMPLE_W:0] total;

    assign a_ext = {a[SAMPLE_W-1], a};
    assign b_ext = {b[SAMPLE_W-1], b};
    // compare runs as a - b through the same adder
    assign b_op  = (op == OP_CMP) ? ~b_ext : b_ext;
    assign cin   = (op == OP_CMP);
    assign total = a_ext + b_op + {{SAMPLE_W{1'b0}}, cin};

    assign res.sum = total;
    assign res.gt  = !total[SAMPLE_W] && (total != '0);

endmodule

@@ src/buffer_median.sv @@
// Insertion: busy stays high after the accept cycle while a sample walks the
// sorted RAM, one shared compare per cycle, each larger entry moving up a slot.
// A last sample then adds RAM reads in S_MED_RD and S_MED_ODD (odd count) or in
// S_MED_RD, S_MED_LO and S_MED_HI (even count), and the done strobe follows in
// the next cycle, for one cycle only. A new word is taken only in S_IDLE.
// Reset: rst_n clears the count and overflow flag; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// buffer_median
// Median of a set of signed Q16.16 samples kept in a sorted RAM.
// ----------------------------------------------------------------------------
module buffer_median
    import bm_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  bm_in_t  item,
    output logic    done,
    output bm_out_t result
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_MED_RD,
        S_MED_ODD,
        S_MED_LO,
        S_MED_HI
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic                ovf_reg, ovf_next;
    logic                last_reg, last_next;
    logic [SAMPLE_W-1:0] x_reg, x_next;
    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic                done_reg, done_next;
    bm_out_t             result_reg, result_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    bm_op_t              unit_op;
    logic [SAMPLE_W-1:0] unit_a;
    logic [SAMPLE_W-1:0] unit_b;
    bm_unit_res_t        unit_res;

    logic [AW-1:0]       half;

    bm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bm_unit u_unit (
        .op  (unit_op),
        .a   (unit_a),
        .b   (unit_b),
        .res (unit_res)
    );

    assign half = AW'(fill_reg >> 1);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        fill_next   = fill_reg;
        ovf_next    = ovf_reg;
        last_next   = last_reg;
        x_next      = x_reg;
        lo_next     = lo_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = x_reg;
        ram_raddr   = '0;
        unit_op     = OP_CMP;
        unit_a      = ram_rdata;
        unit_b      = x_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    x_next    = item.sample;
                    last_next = item.last_of_set;
                    if (fill_reg < CW'(MAX_SAMPLES))
                    begin
                        pos_next = AW'(fill_reg);
                        if (fill_reg == '0)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            ram_raddr  = AW'(fill_reg - 1'b1);
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        // store full: drop the word
                        ovf_next = 1'b1;
                        if (item.last_of_set)
                        begin
                            state_next = S_MED_RD;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                if (unit_res.gt)
                begin
                    // move entry up one slot, fetch the next one down
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - 1'b1;
                    if (pos_reg == AW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        ram_raddr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    ram_wdata  = x_reg;
                    fill_next  = fill_reg + 1'b1;
                    state_next = last_reg ? S_MED_RD : S_IDLE;
                end
            end

            S_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = x_reg;
                fill_next  = fill_reg + 1'b1;
                state_next = last_reg ? S_MED_RD : S_IDLE;
            end

            S_MED_RD:
            begin
                if (fill_reg[0])
                begin
                    ram_raddr  = half;
                    state_next = S_MED_ODD;
                end
                else
                begin
                    ram_raddr  = half - 1'b1;
                    state_next = S_MED_LO;
                end
            end

            S_MED_LO:
            begin
                lo_next    = ram_rdata;
                ram_raddr  = half;
                state_next = S_MED_HI;
            end

            S_MED_HI:
            begin
                unit_op                = OP_ADD;
                unit_a                 = lo_reg;
                unit_b                 = ram_rdata;
                // floor of the 33-bit sum over two
                result_next.median     = unit_res.sum[SAMPLE_W:1];
                result_next.overflowed = ovf_reg;
                done_next              = 1'b1;
                fill_next              = '0;
                ovf_next               = 1'b0;
                state_next             = S_IDLE;
            end

            S_MED_ODD:
            begin
                result_next.median     = ram_rdata;
                result_next.overflowed = ovf_reg;
                done_next              = 1'b1;
                fill_next              = '0;
                ovf_next               = 1'b0;
                state_next             = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            fill_reg   <= '0;
            ovf_reg    <= 1'b0;
            last_reg   <= 1'b0;
            x_reg      <= '0;
            lo_reg     <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            fill_reg   <= fill_next;
            ovf_reg    <= ovf_next;
            last_reg   <= last_next;
            x_reg      <= x_next;
            lo_reg     <= lo_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ src/bm_checker.sv @@
// ----------------------------------------------------------------------------
// bm_checker
// Port-level checks on the buffer median handshake and result timing.
// ----------------------------------------------------------------------------
module bm_checker
    import bm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input bm_in_t  item,
    input logic    done,
    input bm_out_t result
);

    // results never come back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe held for two cycles");

    // a result is shown only while the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted word cannot produce a result in the next cycle
    a_no_fast_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result one cycle after accept");

    // the last word of a set always starts median work
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last_of_set) |=> busy)
        else $error("last word accepted without median work");

    // result word only moves together with the done strobe
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(result) |-> done)
        else $error("result changed without done");

endmodule

bind buffer_median bm_checker u_bm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
